// ===== sv/swr_pkg.sv =====
// Package for the stream word replace unit: word size, register indexes,
// sequencer states and helpers for word bytes and effective lengths.
// No dependencies.
`default_nettype none

package swr_pkg;

    localparam int MAX_WORD  = 16;
    localparam int LEN_W     = $clog2(MAX_WORD + 1);
    localparam int IDX_W     = $clog2(MAX_WORD);
    localparam int CFG_ADR_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam logic [7:0] LINE_BREAK = 8'd10;

    localparam logic [CFG_ADR_W-1:0] REG_FIND_LO = 3'd0;
    localparam logic [CFG_ADR_W-1:0] REG_FIND_HI = 3'd1;
    localparam logic [CFG_ADR_W-1:0] REG_FIND_LEN = 3'd2;
    localparam logic [CFG_ADR_W-1:0] REG_REPL_LO = 3'd3;
    localparam logic [CFG_ADR_W-1:0] REG_REPL_HI = 3'd4;
    localparam logic [CFG_ADR_W-1:0] REG_REPL_LEN = 3'd5;

    typedef logic [7:0] t_word [MAX_WORD];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REPL,
        ST_FLUSH,
        ST_NL,
        ST_FIN
    } t_state;

    // Split the two 64-bit halves into bytes, byte zero lowest.
    function automatic t_word split_word(input logic [63:0] lo, input logic [63:0] hi);
        t_word w;
        for (int j = 0; j < MAX_WORD; j++) begin
            if (j < 8) begin
                w[j] = lo[(j % 8) * 8 +: 8];
            end else if (j < 16) begin
                w[j] = hi[(j % 8) * 8 +: 8];
            end else begin
                w[j] = 8'd0;
            end
        end
        return w;
    endfunction

    // Zero reads as one, anything above the word size saturates.
    function automatic logic [LEN_W-1:0] eff_find_len(input logic [4:0] l);
        logic [LEN_W-1:0] r;
        if (l == 5'd0) begin
            r = LEN_W'(1);
        end else if (32'(l) > MAX_WORD) begin
            r = LEN_W'(MAX_WORD);
        end else begin
            r = LEN_W'(l);
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] eff_repl_len(input logic [4:0] l);
        logic [LEN_W-1:0] r;
        if (32'(l) > MAX_WORD) begin
            r = LEN_W'(MAX_WORD);
        end else begin
            r = LEN_W'(l);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/stream_word_replace_unit.sv =====
// Stream word replace unit: top level, byte sequencer, shared match compare,
// output stage and configuration registers. Depends on swr_pkg.
//
// Text enters on the s_axis channel one byte per word; tlast marks end of
// text, which flushes held bytes and ignores tdata. Edited text leaves on
// m_axis one byte per word; tlast marks the final byte caused by an input
// word. An input word that causes nothing (held bytes of a partial match,
// or end of text with nothing held) produces no output word.
// The configuration port writes the find word, replacement word and their
// lengths by index; write only while the block is idle.
// One input word at a time: s_axis_tready is high only when the sequencer is
// idle. A plain byte is accepted, compared once and closed out. Each byte
// released on a mismatch adds a compare pass of the shared 16-byte compare
// unit, and each replacement or flushed byte adds a step of its own.
// Emitted bytes pass through a one-byte holding slot so the last flag is
// known, then an output register. A stalled receiver holds the sequencer
// once both the slot and the output register are full. Reset clears the
// held-byte count, the registers to their defaults and both output stages;
// no clearing pass.
`default_nettype none

module stream_word_replace_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire  [7:0]                  s_axis_tdata,   // [7:0] text_byte
    input  wire                         s_axis_tlast,   // end_of_text
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
    output logic                        m_axis_tlast,   // last_of_run
    input  wire                         i_cfg_we,
    input  wire  [swr_pkg::CFG_ADR_W-1:0] i_cfg_addr,
    input  wire  [swr_pkg::CFG_DAT_W-1:0] i_cfg_wdata
);

    import swr_pkg::*;

    t_state r_state, n_state;

    logic [63:0] r_find_lo, r_find_hi, r_repl_lo, r_repl_hi;
    logic [4:0]  r_find_len, r_repl_len;

    logic [7:0]       r_buf [MAX_WORD];
    logic [7:0]       n_buf [MAX_WORD];
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_first, n_first;
    logic             r_nl, n_nl;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic       r_pnd_vld, n_pnd_vld;
    logic [7:0] r_pnd_byte, n_pnd_byte;
    logic       r_out_vld, n_out_vld;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;

    t_word            fw, rw;
    logic [LEN_W-1:0] flen, rlen, limit;
    logic             all_eq, match_ok;
    logic             out_free, emit_ok, emit, close;
    logic [7:0]       emit_byte;
    logic             shift;

    assign fw   = split_word(r_find_lo, r_find_hi);
    assign rw   = split_word(r_repl_lo, r_repl_hi);
    assign flen = eff_find_len(r_find_len);
    assign rlen = eff_repl_len(r_repl_len);

    // Shared compare: buffered bytes against the head of the find word.
    always_comb begin
        all_eq = 1'b1;
        for (int j = 0; j < MAX_WORD; j++) begin
            if ((LEN_W'(j) < r_cnt) && (r_buf[j] != fw[j])) begin
                all_eq = 1'b0;
            end
        end
    end

    assign limit    = r_first ? flen : flen - LEN_W'(1);
    assign match_ok = (r_cnt <= limit) && all_eq;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign emit_ok       = !r_pnd_vld || out_free;
    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_nl      = r_nl;
        n_idx     = r_idx;
        n_buf     = r_buf;
        emit      = 1'b0;
        emit_byte = r_buf[0];
        close     = 1'b0;
        shift     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tlast) begin
                        n_nl    = 1'b0;
                        n_state = ST_FLUSH;
                    end else if (s_axis_tdata == LINE_BREAK) begin
                        n_nl    = 1'b1;
                        n_state = ST_FLUSH;
                    end else begin
                        n_buf[r_cnt[IDX_W-1:0]] = s_axis_tdata;
                        n_cnt   = r_cnt + LEN_W'(1);
                        n_first = 1'b1;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (match_ok) begin
                    if (r_cnt == flen) begin
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_state = (rlen == '0) ? ST_FIN : ST_REPL;
                    end else begin
                        n_state = ST_FIN;
                    end
                end else if (emit_ok) begin
                    // release the head byte, retry one position later
                    emit    = 1'b1;
                    shift   = 1'b1;
                    n_cnt   = r_cnt - LEN_W'(1);
                    n_first = 1'b0;
                end
            end
            ST_REPL: begin
                emit_byte = rw[r_idx];
                if (emit_ok) begin
                    emit  = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                    if ({1'b0, r_idx} == rlen - LEN_W'(1)) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FLUSH: begin
                if (r_cnt == '0) begin
                    n_state = r_nl ? ST_NL : ST_FIN;
                end else if (emit_ok) begin
                    emit  = 1'b1;
                    shift = 1'b1;
                    n_cnt = r_cnt - LEN_W'(1);
                end
            end
            ST_NL: begin
                emit_byte = LINE_BREAK;
                if (emit_ok) begin
                    emit    = 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // push the held-back byte with the last flag set
                if (!r_pnd_vld) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    close   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (shift) begin
            for (int j = 0; j < MAX_WORD - 1; j++) begin
                n_buf[j] = r_buf[j + 1];
            end
        end
    end

    // Holding slot and output register.
    always_comb begin
        n_pnd_vld  = r_pnd_vld;
        n_pnd_byte = r_pnd_byte;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        if (emit) begin
            if (r_pnd_vld) begin
                n_out_vld  = 1'b1;
                n_out_byte = r_pnd_byte;
                n_out_last = 1'b0;
            end
            n_pnd_vld  = 1'b1;
            n_pnd_byte = emit_byte;
        end else if (close) begin
            n_out_vld  = 1'b1;
            n_out_byte = r_pnd_byte;
            n_out_last = 1'b1;
            n_pnd_vld  = 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_first   <= 1'b0;
            r_nl      <= 1'b0;
            r_idx     <= '0;
            r_pnd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_first   <= n_first;
            r_nl      <= n_nl;
            r_idx     <= n_idx;
            r_pnd_vld <= n_pnd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        r_pnd_byte <= n_pnd_byte;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_lo  <= '0;
            r_find_hi  <= '0;
            r_find_len <= 5'd1;
            r_repl_lo  <= '0;
            r_repl_hi  <= '0;
            r_repl_len <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FIND_LO:  r_find_lo  <= i_cfg_wdata;
                REG_FIND_HI:  r_find_hi  <= i_cfg_wdata;
                REG_FIND_LEN: r_find_len <= i_cfg_wdata[4:0];
                REG_REPL_LO:  r_repl_lo  <= i_cfg_wdata;
                REG_REPL_HI:  r_repl_hi  <= i_cfg_wdata;
                REG_REPL_LEN: r_repl_len <= i_cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_stream_word_replace_unit.sv =====
// Self-checking testbench for stream_word_replace_unit: a directed table, then random
// phases of text with matches, partial matches, line breaks and end-of-text flushes.
// Depends on swr_pkg and the unit; output words are checked by a predictor or typed rows.
`default_nettype none

module tb_stream_word_replace_unit;
    import swr_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 44;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_edited;

    typedef enum logic [1:0] {
        ROW_TEXT,
        ROW_EOT,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_ADR_W-1:0]   reg_idx;
        logic [CFG_DAT_W-1:0]   value;
        logic                   typed;       // expectation given in the row
        logic                   n_typed;     // zero or one output word
        logic [7:0]             typed_byte;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_BEAT,
        RX_COIN,
        RX_STARVE
    } t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] text_byte
    logic                   s_axis_tlast;   // end_of_text
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;   // [7:0] out_byte
    logic                   m_axis_tlast;   // last_of_run
    logic                   i_cfg_we;
    logic [CFG_ADR_W-1:0]   i_cfg_addr;
    logic [CFG_DAT_W-1:0]   i_cfg_wdata;

    // Shadow of the configuration and of the partial match
    logic [63:0] find_lo, find_hi, repl_lo, repl_hi;
    logic [4:0]  find_len, repl_len;
    logic [7:0]  held [MAX_WORD-1];
    int          held_cnt;

    t_edited     bytes_due [$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    int          rx_tick = 0;
    t_rx_mode    rx_mode = RX_FREE;
    t_dir_row    directed_rows [37];

    stream_word_replace_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: drive ready from a stall pattern that is redrawn at random
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_FREE:  m_axis_tready <= 1'b1;
            RX_BEAT:  m_axis_tready <= (rx_tick % 3) != 0;
            RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
            default:  m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin : out_check
        t_edited want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (bytes_due.size() == 0) begin
                $error("out_byte: unexpected word, got %02h", m_axis_tdata);
                fail_count++;
            end else begin
                want = bytes_due.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    function automatic int find_span();
        int n;
        n = find_len;
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_WORD) begin
            n = MAX_WORD;
        end
        return n;
    endfunction

    function automatic logic [7:0] find_byte(input int j);
        logic [127:0] w;
        w = {find_hi, find_lo};
        return w[j*8 +: 8];
    endfunction

    // Advance the match state by one text word; queue the edited bytes if keep is set
    function automatic void edit_text_byte(input logic [7:0] b, input logic eot,
                                           input bit keep);
        logic [7:0]   seq [MAX_WORD];
        logic [7:0]   outs [$];
        logic [127:0] rw;
        t_edited      e;
        int           len, flen, rlen, k, rem, limit;
        bit           found;
        if (eot || b == LINE_BREAK) begin
            for (int j = 0; j < held_cnt; j++) begin
                outs.push_back(held[j]);
            end
            held_cnt = 0;
            if (!eot) begin
                outs.push_back(b);
            end
        end else begin
            for (int j = 0; j < held_cnt; j++) begin
                seq[j] = held[j];
            end
            seq[held_cnt] = b;
            len = held_cnt + 1;
            flen = find_span();
            // Shortest release after which the rest is still a prefix of the find word
            k = 0;
            found = 1'b0;
            while (!found && k < len) begin
                rem = len - k;
                limit = (k == 0) ? flen : flen - 1;
                if (rem <= limit) begin
                    found = 1'b1;
                    for (int j = 0; j < rem; j++) begin
                        if (seq[k+j] != find_byte(j)) begin
                            found = 1'b0;
                        end
                    end
                end
                if (!found) begin
                    k++;
                end
            end
            rem = len - k;
            for (int j = 0; j < k; j++) begin
                outs.push_back(seq[j]);
            end
            if (rem == flen) begin
                rlen = (repl_len > MAX_WORD) ? MAX_WORD : repl_len;
                rw = {repl_hi, repl_lo};
                for (int j = 0; j < rlen; j++) begin
                    outs.push_back(rw[j*8 +: 8]);
                end
                held_cnt = 0;
            end else begin
                for (int j = 0; j < rem; j++) begin
                    held[j] = seq[k+j];
                end
                held_cnt = rem;
            end
        end
        if (keep) begin
            for (int j = 0; j < outs.size(); j++) begin
                e.data = outs[j];
                e.last = (j == outs.size() - 1);
                bytes_due.push_back(e);
            end
        end
    endfunction

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic send_text(input logic [7:0] b, input logic eot, input bit typed = 1'b0,
                             input logic n_typed = 1'b0, input logic [7:0] typed_byte = 8'h00);
        t_edited e;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        edit_text_byte(b, eot, !typed);
        if (typed && n_typed) begin
            e.data = typed_byte;
            e.last = 1'b1;
            bytes_due.push_back(e);
        end
        pace_sender();
    endtask

    // Hold the sender until every word has come out, then let the sequencer go idle
    task automatic drain_output();
        s_axis_tvalid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADR_W-1:0] idx, input logic [CFG_DAT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FIND_LO:  find_lo  = v;
            REG_FIND_HI:  find_hi  = v;
            REG_FIND_LEN: find_len = v[4:0];
            REG_REPL_LO:  repl_lo  = v;
            REG_REPL_HI:  repl_hi  = v;
            REG_REPL_LEN: repl_len = v[4:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int shape, input int n_items);
        logic [7:0]   sym [2];
        logic [127:0] word;
        logic [63:0]  len_bits;
        int           flen_raw, rlen_raw, sent, r, n, pos;
        bit           wild;
        sym[0] = 8'($urandom_range(0, 255));
        sym[1] = 8'($urandom_range(0, 255));
        wild = ($urandom_range(0, 4) == 0);
        for (int j = 0; j < MAX_WORD; j++) begin
            word[j*8 +: 8] = wild ? 8'($urandom_range(0, 255)) : sym[$urandom_range(0, 1)];
        end
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, MAX_WORD - 1);
            word[pos*8 +: 8] = LINE_BREAK;
        end
        case (shape)
            0: begin flen_raw = 16; rlen_raw = 16; end
            1: begin flen_raw = 1;  rlen_raw = 0;  end
            2: begin flen_raw = 31; rlen_raw = 31; end
            3: begin flen_raw = 0;  rlen_raw = 17; end
            default: begin
                r = $urandom_range(0, 9);
                flen_raw = (r == 0) ? $urandom_range(17, 31) : (r == 1) ? 0 :
                           (r == 2) ? 16 : $urandom_range(1, 5);
                r = $urandom_range(0, 9);
                rlen_raw = (r == 0) ? $urandom_range(17, 31) : (r == 1) ? 0 :
                           (r == 2) ? 16 : $urandom_range(1, 6);
            end
        endcase

        drain_output();
        write_reg(REG_FIND_LO, word[63:0]);
        write_reg(REG_FIND_HI, word[127:64]);
        len_bits = {$urandom, $urandom};
        len_bits[4:0] = 5'(flen_raw);
        write_reg(REG_FIND_LEN, len_bits);
        write_reg(REG_REPL_LO, {$urandom, $urandom});
        write_reg(REG_REPL_HI, {$urandom, $urandom});
        len_bits = {$urandom, $urandom};
        len_bits[4:0] = 5'(rlen_raw);
        write_reg(REG_REPL_LEN, len_bits);

        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            n = find_span();
            if (r < 30) begin
                for (int j = 0; j < n; j++) begin
                    send_text(find_byte(j), 1'b0);
                end
                sent += n;
            end else if (r < 45) begin
                // possibly broken sequence: a prefix, up to the whole word
                n = $urandom_range(1, n);
                for (int j = 0; j < n; j++) begin
                    send_text(find_byte(j), 1'b0);
                end
                sent += n;
            end else begin
                if (r < 70) begin
                    send_text(sym[$urandom_range(0, 1)], 1'b0);
                end else if (r < 82) begin
                    send_text(8'($urandom_range(0, 255)), 1'b0);
                end else if (r < 92) begin
                    send_text(LINE_BREAK, 1'b0);
                end else begin
                    send_text(8'($urandom_range(0, 255)), 1'b1);
                end
                sent++;
            end
        end
        // Leave a partial match held now and then across the next register change
        if ($urandom_range(0, 3) != 0) begin
            send_text(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_FIND_LO;
        i_cfg_wdata   = '0;
        find_lo  = '0;
        find_hi  = '0;
        find_len = 5'd1;
        repl_lo  = '0;
        repl_hi  = '0;
        repl_len = 5'd1;
        held_cnt = 0;

        directed_rows = '{
            // reset words: find 00, replace with 00
            '{ROW_TEXT, '0, 64'h41, 1'b1, 1'b1, 8'h41},
            '{ROW_TEXT, '0, 64'h00, 1'b1, 1'b1, 8'h00},
            '{ROW_TEXT, '0, 64'hFF, 1'b1, 1'b1, 8'hFF},
            '{ROW_TEXT, '0, 64'h0A, 1'b1, 1'b1, 8'h0A},
            '{ROW_EOT,  '0, 64'hA5, 1'b1, 1'b0, 8'h00},
            // find "abc", sixteen-byte replacement through a saturated length
            '{ROW_REG, REG_FIND_LO,  64'h0000_0000_0063_6261, 1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_FIND_HI,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_FIND_LEN, 64'd3,                   1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_REPL_LO,  64'h4847_4645_4443_4241, 1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_REPL_HI,  64'h504F_4E4D_4C4B_4A49, 1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_REPL_LEN, 64'd31,                  1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h61, 1'b1, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h62, 1'b1, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h63, 1'b0, 1'b0, 8'h00},
            // fallback on "aab", then a line break flushes the held prefix
            '{ROW_TEXT, '0, 64'h61, 1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h61, 1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h62, 1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h0A, 1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h61, 1'b1, 1'b0, 8'h00},
            '{ROW_EOT,  '0, 64'h5A, 1'b1, 1'b1, 8'h61},
            // zero lengths: find reads as one byte, match is deleted
            '{ROW_REG, REG_REPL_LEN, 64'd0, 1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_FIND_LEN, 64'd0, 1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h61, 1'b1, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h62, 1'b1, 1'b1, 8'h62},
            // line break inside the find word never matches
            '{ROW_REG, REG_FIND_LO,  64'h0A61, 1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_FIND_LEN, 64'd2,    1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h61, 1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'h0A, 1'b0, 1'b0, 8'h00},
            // shorten the find word while three bytes are held
            '{ROW_REG, REG_FIND_LO,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_FIND_LEN, 64'd31,                  1'b0, 1'b0, 8'h00},
            '{ROW_REG, REG_REPL_LEN, 64'd1,                   1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_REG, REG_FIND_LEN, 64'd4, 1'b0, 1'b0, 8'h00},
            '{ROW_TEXT, '0, 64'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_EOT,  '0, 64'h3C, 1'b1, 1'b0, 8'h00}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(directed_rows); i++) begin
            if (directed_rows[i].kind == ROW_REG) begin
                if (i == 0 || directed_rows[i-1].kind != ROW_REG) begin
                    drain_output();
                end
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_text(directed_rows[i].value[7:0], directed_rows[i].kind == ROW_EOT,
                          directed_rows[i].typed, directed_rows[i].n_typed,
                          directed_rows[i].typed_byte);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            random_phase(p, PHASE_ITEMS);
        end

        drain_output();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
